FILE: sv/imt_pkg.sv
// ----------------------------------------------------------------------------
// imt_pkg
// Shared types and constants of the in-place matrix transposer.
// ----------------------------------------------------------------------------
package imt_pkg;

	localparam int IDX_W   = 10;
	localparam int DIM_W   = 11;
	localparam int TOTAL_W = 2 * DIM_W;
	localparam int VALUE_W = 64;

	typedef enum logic [1:0] {
		KIND_WRITE     = 2'd0,
		KIND_READ      = 2'd1,
		KIND_TRANSPOSE = 2'd2
	} kind_t;

	typedef enum logic {
		REG_ROW_COUNT    = 1'b0,
		REG_COLUMN_COUNT = 1'b1
	} reg_index_t;

	typedef struct packed {
		kind_t              kind;
		logic [IDX_W-1:0]   element_index;
		logic [VALUE_W-1:0] element_value;
	} request_t;

	typedef struct packed {
		logic [VALUE_W-1:0] read_value;
		logic               error;
	} result_t;

	typedef struct packed {
		logic [DIM_W-1:0] row_count;
		logic [DIM_W-1:0] column_count;
	} cfg_t;

	typedef struct packed {
		logic    valid;
		result_t payload;
	} pending_t;

endpackage

FILE: sv/imt_stream_if.sv
// ----------------------------------------------------------------------------
// imt_stream_if
// Valid/ready channel carrying one request or one result per transfer.
// ----------------------------------------------------------------------------
interface imt_stream_if #(
	parameter type payload_t = logic
) ();

	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);

endinterface

FILE: sv/imt_ram.sv
// ----------------------------------------------------------------------------
// imt_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module imt_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

FILE: sv/imt_engine.sv
// ----------------------------------------------------------------------------
// imt_engine
// Request decoder and transpose sequencer around the element and link RAMs.
// ----------------------------------------------------------------------------
module imt_engine import imt_pkg::*; #(
	parameter int MAX_ELEMENTS = 1024,
	parameter int WORD_BITS    = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	imt_stream_if.sink            request,
	input  cfg_t                  cfg,
	output pending_t              pending,
	input  logic                  pending_take
);

	localparam int AW = $clog2(MAX_ELEMENTS);
	localparam int LW = AW + 1;

	typedef enum logic [6:0] {
		ST_IDLE     = 7'b0000001,
		ST_READ     = 7'b0000010,
		ST_FILL     = 7'b0000100,
		ST_SCAN_RD  = 7'b0001000,
		ST_SCAN_CHK = 7'b0010000,
		ST_WALK     = 7'b0100000,
		ST_DONE     = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	logic [AW-1:0]        s_q, pos_q, last_q, row_q, col_q, dest_q;
	logic [WORD_BITS-1:0] carry_q;
	logic                 fwd_q;
	logic [VALUE_W-1:0]   pend_value_q;
	logic                 pend_error_q;

	logic                 d_we, d_re;
	logic [AW-1:0]        d_waddr, d_raddr;
	logic [WORD_BITS-1:0] d_wdata, d_rdata;
	logic                 l_we, l_re;
	logic [AW-1:0]        l_waddr, l_raddr;
	logic [LW-1:0]        l_wdata, l_rdata;

	logic [TOTAL_W-1:0]    total, total_m1, dest_sum;
	logic                  shape_ok, idx_ok, item_ok, accept, col_wrap;
	logic [AW+IDX_W-1:0]   idx_ext;
	logic [AW-1:0]         idx_addr, link_dest;
	logic                  link_vis;

	assign total    = TOTAL_W'(cfg.row_count) * TOTAL_W'(cfg.column_count);
	assign total_m1 = total - TOTAL_W'(1);
	assign shape_ok = (cfg.row_count != '0) && (cfg.column_count != '0) &&
		(total <= TOTAL_W'(MAX_ELEMENTS));
	assign idx_ok   = TOTAL_W'(request.payload.element_index) < total;
	assign idx_ext  = (AW + IDX_W)'(request.payload.element_index);
	assign idx_addr = idx_ext[AW-1:0];

	assign request.ready = (state_q == ST_IDLE);
	assign accept        = request.valid && request.ready;

	assign link_dest = l_rdata[AW-1:0];
	assign link_vis  = l_rdata[AW] || (fwd_q && (state_q == ST_WALK));
	assign col_wrap  = (TOTAL_W'(col_q) + TOTAL_W'(1)) == TOTAL_W'(cfg.column_count);
	assign dest_sum  = TOTAL_W'(dest_q) + TOTAL_W'(cfg.row_count);

	always_comb begin
		case (request.payload.kind)
			KIND_WRITE, KIND_READ: item_ok = shape_ok && idx_ok;
			KIND_TRANSPOSE:        item_ok = shape_ok;
			default:               item_ok = 1'b0;
		endcase
	end

	always_comb begin
		state_d = state_q;
		d_we    = 1'b0;
		d_waddr = pos_q;
		d_wdata = carry_q;
		d_re    = 1'b0;
		d_raddr = link_dest;
		l_we    = 1'b0;
		l_waddr = pos_q;
		l_wdata = {1'b1, link_dest};
		l_re    = 1'b0;
		l_raddr = link_dest;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_DONE;
					if (item_ok) begin
						case (request.payload.kind)
							KIND_WRITE: begin
								d_we    = 1'b1;
								d_waddr = idx_addr;
								d_wdata = request.payload.element_value[WORD_BITS-1:0];
							end
							KIND_READ: begin
								d_re    = 1'b1;
								d_raddr = idx_addr;
								state_d = ST_READ;
							end
							KIND_TRANSPOSE: state_d = ST_FILL;
							default: state_d = ST_DONE;
						endcase
					end
				end
			end
			ST_READ: state_d = ST_DONE;
			ST_FILL: begin
				l_we    = 1'b1;
				l_waddr = s_q;
				l_wdata = {1'b0, dest_q};
				if (s_q == last_q) begin
					state_d = ST_SCAN_RD;
				end
			end
			ST_SCAN_RD: begin
				d_re    = 1'b1;
				d_raddr = s_q;
				l_re    = 1'b1;
				l_raddr = s_q;
				state_d = ST_SCAN_CHK;
			end
			ST_SCAN_CHK: begin
				if (link_vis) begin
					state_d = (s_q == last_q) ? ST_DONE : ST_SCAN_RD;
				end else begin
					l_we    = 1'b1;
					l_waddr = s_q;
					d_re    = 1'b1;
					l_re    = 1'b1;
					state_d = ST_WALK;
				end
			end
			ST_WALK: begin
				d_we = 1'b1;
				if (link_vis) begin
					state_d = (s_q == last_q) ? ST_DONE : ST_SCAN_RD;
				end else begin
					l_we = 1'b1;
					d_re = 1'b1;
					l_re = 1'b1;
				end
			end
			ST_DONE: begin
				if (pending_take) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					pend_value_q <= '0;
					pend_error_q <= !item_ok;
					s_q          <= '0;
					row_q        <= '0;
					col_q        <= '0;
					dest_q       <= '0;
					last_q       <= total_m1[AW-1:0];
				end
			end
			ST_READ: pend_value_q <= VALUE_W'(d_rdata);
			ST_FILL: begin
				if (s_q == last_q) begin
					s_q <= '0;
				end else begin
					s_q <= s_q + AW'(1);
					if (col_wrap) begin
						col_q  <= '0;
						row_q  <= row_q + AW'(1);
						dest_q <= row_q + AW'(1);
					end else begin
						col_q  <= col_q + AW'(1);
						dest_q <= dest_sum[AW-1:0];
					end
				end
			end
			ST_SCAN_CHK: begin
				if (link_vis) begin
					s_q <= s_q + AW'(1);
				end else begin
					carry_q <= d_rdata;
					pos_q   <= link_dest;
					fwd_q   <= (link_dest == s_q);
				end
			end
			ST_WALK: begin
				carry_q <= d_rdata;
				if (link_vis) begin
					s_q <= s_q + AW'(1);
				end else begin
					pos_q <= link_dest;
					fwd_q <= (link_dest == pos_q);
				end
			end
			default: begin
			end
		endcase
	end

	assign pending.valid              = (state_q == ST_DONE);
	assign pending.payload.read_value = pend_value_q;
	assign pending.payload.error      = pend_error_q;

	imt_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (MAX_ELEMENTS)
	) u_element_ram (
		.clk     (clk),
		.wr_en   (d_we),
		.wr_addr (d_waddr),
		.wr_data (d_wdata),
		.rd_en   (d_re),
		.rd_addr (d_raddr),
		.rd_data (d_rdata)
	);

	imt_ram #(
		.WIDTH (LW),
		.DEPTH (MAX_ELEMENTS)
	) u_link_ram (
		.clk     (clk),
		.wr_en   (l_we),
		.wr_addr (l_waddr),
		.wr_data (l_wdata),
		.rd_en   (l_re),
		.rd_addr (l_raddr),
		.rd_data (l_rdata)
	);

endmodule

FILE: sv/in_place_matrix_transposer_core.sv
// ----------------------------------------------------------------------------
// in_place_matrix_transposer_core
// Row-major word store with element write, element read and in-place transpose.
// ----------------------------------------------------------------------------
// A write request goes from idle straight to the done state; a read request
// passes through a read state to take the registered element RAM data. A
// transpose of N = rows * columns elements first writes the link RAM with
// each position's destination and a cleared visited mark, then scans each
// start position through a read state and a check state, and walks each
// unvisited permutation cycle to move its elements to their destinations.
// Every request gives one result; refused requests return error with a zero
// value and change nothing. The element RAM is not cleared after reset.
module in_place_matrix_transposer_core import imt_pkg::*; #(
	parameter int MAX_ELEMENTS = 1024,
	parameter int WORD_BITS    = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	imt_stream_if.sink        request,
	imt_stream_if.source      result,
	input  logic              cfg_wr_en,
	input  reg_index_t        cfg_index,
	input  logic [DIM_W-1:0]  cfg_data
);

	cfg_t     cfg_q;
	pending_t pending;
	logic     pending_take;
	logic     out_valid_q;
	result_t  out_payload_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.row_count    <= DIM_W'(1);
			cfg_q.column_count <= DIM_W'(1);
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_ROW_COUNT:    cfg_q.row_count    <= cfg_data;
				REG_COLUMN_COUNT: cfg_q.column_count <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign pending_take = pending.valid && (!out_valid_q || result.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pending_take) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pending_take) begin
			out_payload_q <= pending.payload;
		end
	end

	assign result.valid   = out_valid_q;
	assign result.payload = out_payload_q;

	imt_engine #(
		.MAX_ELEMENTS (MAX_ELEMENTS),
		.WORD_BITS    (WORD_BITS)
	) u_engine (
		.clk          (clk),
		.arst_n       (arst_n),
		.request      (request),
		.cfg          (cfg_q),
		.pending      (pending),
		.pending_take (pending_take)
	);

endmodule

FILE: sv/imt_checker.sv
// ----------------------------------------------------------------------------
// imt_checker
// Port-level checks on request and result ordering of the transposer core.
// ----------------------------------------------------------------------------
module imt_checker import imt_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    req_valid,
	input logic    req_ready,
	input logic    res_valid,
	input logic    res_ready,
	input result_t res_payload
);

	logic [1:0] outstanding_q;
	logic       req_acc, res_acc;

	assign req_acc = req_valid && req_ready;
	assign res_acc = res_valid && res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outstanding_q <= '0;
		end else if (req_acc && !res_acc) begin
			outstanding_q <= outstanding_q + 2'd1;
		end else if (res_acc && !req_acc) begin
			outstanding_q <= outstanding_q - 2'd1;
		end
	end

	// A waiting result keeps its value until it is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_payload))
		else $error("result changed while stalled");

	// No result is delivered without a request to answer.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_acc |-> outstanding_q != 2'd0)
		else $error("result without a request");

	// At most one request waits behind a held result, and it blocks intake.
	assert property (@(posedge clk) disable iff (!arst_n)
		outstanding_q == 2'd2 |-> !req_ready && outstanding_q != 2'd3)
		else $error("too many requests in flight");

	// A refused request never returns data.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_payload.error |-> res_payload.read_value == '0)
		else $error("error result carries data");

endmodule

bind in_place_matrix_transposer_core imt_checker u_imt_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (request.valid),
	.req_ready   (request.ready),
	.res_valid   (result.valid),
	.res_ready   (result.ready),
	.res_payload (result.payload)
);
